[rtl/rk4q_pkg.sv]
package rk4q_pkg;

  localparam int FRAC_BITS = 24;
  localparam int COEF_FRAC = 12;
  localparam int SUM_W     = 36;
  localparam int ACC_W     = 52;
  localparam int CNT_W     = 10;
  localparam int SLOT_W    = 9;
  localparam int DIV_STEPS = 5;
  localparam int DIV_CHUNK = 16;
  localparam int DIV_SHIFT = 24;
  localparam int REM_W     = 23;
  // 2^16 = 6 * 10922 + 4; the folded remainder is multiplied by ceil(2^24 / 6), then >> 24
  localparam logic signed [31:0] DIV_HI_MUL = 32'sd10922;
  localparam logic signed [31:0] DIV_RECIP  = 32'sd2796203;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_USE, S_STEP, S_DIV, S_END, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_UU, OP_VV, OP_UV, OP_BU, OP_CV, OP_DUU, OP_EVV, OP_FUV, OP_TAU, OP_HD,
    OP_QH, OP_QR
  } op_t;

  typedef enum logic [2:0] {
    CFG_X_ABCD, CFG_X_EFTI, CFG_Y_ABCD, CFG_Y_EFTI,
    CFG_STEP, CFG_TRAIL_LEN, CFG_TIME_LIMIT, CFG_RUN_MODE
  } cfg_idx_t;

  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_PLACE   = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[rtl/rk4_quadratic_field_particle_step.sv]
// channel | ports   | fields, lowest bits first
// in      | in_t*   | tdata place_x, place_y; tuser req_type
// out     | out_t*  | tdata new_x, new_y, disp_x, disp_y, trail_slot; tuser outside_box, trail_wrapped
// cfg     | cfg_*   | cfg_addr index, cfg_wdata data, written on cfg_wr_en
// An advance request runs 80 field products on one shared 32x32 multiplier, each in a
// multiply and a use state, four stage updates, a divide by six that puts four products
// through the same multiplier, then one finish and one emit state. A place request goes
// from idle straight to emit.
// in_tready is high only in idle. A finished result waits in the output register while
// out_tready is low; the next result then holds in emit.
// Reset (rst_n low, synchronous) clears position, start, trail count and flag.
module rk4_quadratic_field_particle_step
  import rk4q_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // place_x, place_y
  input  logic [0:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // new_x, new_y, disp_x, disp_y, trail_slot, zero pad
  output logic [1:0]   out_tuser,  // outside_box, trail_wrapped
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [63:0] cx_abcd_r, cx_efti_r, cy_abcd_r, cy_efti_r;
  logic [23:0] step_r;
  logic [SLOT_W-1:0] tlen_r;
  logic [1:0]  mode_r;

  logic signed [31:0] pos_x_r, pos_y_r, start_x_r, start_y_r;
  logic signed [31:0] pos_x_nxt, pos_y_nxt, start_x_nxt, start_y_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic full_r, full_nxt;

  logic signed [31:0] ex_r, ey_r, ex_nxt, ey_nxt;
  logic signed [31:0] uu_r, vv_r, uv_r, d_r, kx_r, ky_r;
  logic signed [31:0] uu_nxt, vv_nxt, uv_nxt, d_nxt, kx_nxt, ky_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic [SUM_W-1:0] qx_r, qy_r, qx_nxt, qy_nxt;
  logic [REM_W-1:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic [5:0] dcnt_r, dcnt_nxt;
  op_t op_r, op_nxt;
  logic axis_r, axis_nxt;
  logic [1:0] stage_r, stage_nxt;

  logic signed [31:0] rx_res_r, ry_res_r, dx_res_r, dy_res_r;
  logic signed [31:0] rx_res_nxt, ry_res_nxt, dx_res_nxt, dy_res_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic out_v_r, out_v_nxt;
  logic [143:0] out_d_r, out_d_nxt;
  logic [1:0] out_u_r, out_u_nxt;

  logic in_acc, out_free;
  logic signed [31:0] u, v, opa, opb, h, poly, lim;
  logic signed [63:0] mul_res;
  logic [63:0] abcd, efti;
  logic signed [15:0] ca, cb, cc, cd, ce, cf, ctau, cin;
  logic signed [SUM_W-1:0] qxs, qys;
  logic signed [31:0] ix, iy;
  logic [CNT_W-1:0] cinc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

  assign u    = axis_r ? ey_r : ex_r;
  assign v    = axis_r ? ex_r : ey_r;
  assign abcd = axis_r ? cy_abcd_r : cx_abcd_r;
  assign efti = axis_r ? cy_efti_r : cx_efti_r;
  assign ca = abcd[15:0];
  assign cb = abcd[31:16];
  assign cc = abcd[47:32];
  assign cd = abcd[63:48];
  assign ce = efti[15:0];
  assign cf = efti[31:16];
  assign ctau = efti[47:32];
  assign cin  = efti[63:48];
  assign h = mode_r[0] ? -$signed({8'd0, step_r}) : $signed({8'd0, step_r});
  assign poly = sat32(64'(acc_r >>> COEF_FRAC));
  assign lim = 32'sd2 <<< FRAC_BITS;
  assign qxs = sx_r[SUM_W-1] ? -$signed(qx_r) : $signed(qx_r);
  assign qys = sy_r[SUM_W-1] ? -$signed(qy_r) : $signed(qy_r);
  assign ix = sat32(64'(pos_x_r) + 64'(qxs));
  assign iy = sat32(64'(pos_y_r) + 64'(qys));
  assign cinc = cnt_r + CNT_W'(1);
  assign mul_res = opa * opb;

  always_comb begin
    unique case (op_r)
      OP_UU:  begin opa = u;           opb = u;    end
      OP_VV:  begin opa = v;           opb = v;    end
      OP_UV:  begin opa = u;           opb = v;    end
      OP_BU:  begin opa = 32'(cb);     opb = u;    end
      OP_CV:  begin opa = 32'(cc);     opb = v;    end
      OP_DUU: begin opa = 32'(cd);     opb = uu_r; end
      OP_EVV: begin opa = 32'(ce);     opb = vv_r; end
      OP_FUV: begin opa = 32'(cf);     opb = uv_r; end
      OP_TAU: begin opa = poly;        opb = 32'(ctau); end
      OP_HD:  begin opa = h;           opb = d_r;  end
      OP_QH:  begin
        opa = axis_r ? 32'(qy_r[SUM_W-1:DIV_CHUNK]) : 32'(qx_r[SUM_W-1:DIV_CHUNK]);
        opb = DIV_HI_MUL;
      end
      OP_QR:  begin
        opa = axis_r ? 32'(ry_r) : 32'(rx_r);
        opb = DIV_RECIP;
      end
      default: begin opa = '0;         opb = '0;   end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = (in_tuser[0] == REQ_PLACE) ? S_EMIT : S_MUL;
      S_MUL:  state_nxt = S_USE;
      S_USE:  state_nxt = (op_r == OP_HD && axis_r) ? S_STEP : S_MUL;
      S_STEP: state_nxt = (stage_r == 2'd3) ? S_DIV : S_MUL;
      S_DIV:  if (dcnt_r == 6'(DIV_STEPS - 1)) state_nxt = S_END;
      S_END:  state_nxt = S_EMIT;
      S_EMIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pos_x_nxt = pos_x_r; pos_y_nxt = pos_y_r;
    start_x_nxt = start_x_r; start_y_nxt = start_y_r;
    cnt_nxt = cnt_r; full_nxt = full_r;
    ex_nxt = ex_r; ey_nxt = ey_r;
    uu_nxt = uu_r; vv_nxt = vv_r; uv_nxt = uv_r; d_nxt = d_r;
    kx_nxt = kx_r; ky_nxt = ky_r; acc_nxt = acc_r; prod_nxt = prod_r;
    sx_nxt = sx_r; sy_nxt = sy_r; qx_nxt = qx_r; qy_nxt = qy_r;
    rx_nxt = rx_r; ry_nxt = ry_r; dcnt_nxt = dcnt_r;
    op_nxt = op_r; axis_nxt = axis_r; stage_nxt = stage_r;
    rx_res_nxt = rx_res_r; ry_res_nxt = ry_res_r;
    dx_res_nxt = dx_res_r; dy_res_nxt = dy_res_r; slot_nxt = slot_r;
    out_v_nxt = out_v_r && !out_tready;
    out_d_nxt = out_d_r; out_u_nxt = out_u_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        if (in_tuser[0] == REQ_PLACE) begin
          pos_x_nxt = in_tdata[31:0];  start_x_nxt = in_tdata[31:0];
          pos_y_nxt = in_tdata[63:32]; start_y_nxt = in_tdata[63:32];
          rx_res_nxt = in_tdata[31:0]; ry_res_nxt = in_tdata[63:32];
          dx_res_nxt = '0; dy_res_nxt = '0; slot_nxt = '0;
        end else begin
          ex_nxt = pos_x_r; ey_nxt = pos_y_r;
          sx_nxt = '0; sy_nxt = '0;
          op_nxt = OP_UU; axis_nxt = 1'b0; stage_nxt = 2'd0;
        end
      end
      S_MUL: prod_nxt = mul_res;
      S_USE: begin
        op_nxt = op_t'(op_r + 4'd1);
        unique case (op_r) inside
          OP_UU: uu_nxt = sat32(prod_r >>> FRAC_BITS);
          OP_VV: vv_nxt = sat32(prod_r >>> FRAC_BITS);
          OP_UV: uv_nxt = sat32(prod_r >>> FRAC_BITS);
          OP_BU: acc_nxt = (ACC_W'(ca) <<< FRAC_BITS) + prod_r[ACC_W-1:0];
          OP_CV, OP_DUU, OP_EVV, OP_FUV: acc_nxt = acc_r + prod_r[ACC_W-1:0];
          OP_TAU: d_nxt = sat32(64'(prod_r >>> COEF_FRAC) + (64'(cin) <<< COEF_FRAC));
          OP_HD: begin
            op_nxt = OP_UU;
            axis_nxt = !axis_r;
            if (axis_r) ky_nxt = prod_r[55:24];
            else kx_nxt = prod_r[55:24];
          end
          default: op_nxt = OP_UU;
        endcase
      end
      S_STEP: begin
        stage_nxt = stage_r + 2'd1;
        if (stage_r == 2'd1 || stage_r == 2'd2) begin
          sx_nxt = sx_r + (SUM_W'(kx_r) <<< 1);
          sy_nxt = sy_r + (SUM_W'(ky_r) <<< 1);
        end else begin
          sx_nxt = sx_r + SUM_W'(kx_r);
          sy_nxt = sy_r + SUM_W'(ky_r);
        end
        if (stage_r == 2'd2) begin
          ex_nxt = sat32(64'(pos_x_r) + 64'(kx_r));
          ey_nxt = sat32(64'(pos_y_r) + 64'(ky_r));
        end else begin
          ex_nxt = sat32(64'(pos_x_r) + 64'(kx_r >>> 1));
          ey_nxt = sat32(64'(pos_y_r) + 64'(ky_r >>> 1));
        end
        qx_nxt = sx_nxt[SUM_W-1] ? SUM_W'(-sx_nxt) : SUM_W'(sx_nxt);
        qy_nxt = sy_nxt[SUM_W-1] ? SUM_W'(-sy_nxt) : SUM_W'(sy_nxt);
        rx_nxt = '0; ry_nxt = '0; dcnt_nxt = '0;
        if (stage_r == 2'd3) op_nxt = OP_QH;
      end
      S_DIV: begin
        dcnt_nxt = dcnt_r + 6'd1;
        prod_nxt = mul_res;
        case (dcnt_r)
          6'd0: begin
            rx_nxt = REM_W'({qx_r[SUM_W-1:DIV_CHUNK], 2'b00}) + REM_W'(qx_r[DIV_CHUNK-1:0]);
            ry_nxt = REM_W'({qy_r[SUM_W-1:DIV_CHUNK], 2'b00}) + REM_W'(qy_r[DIV_CHUNK-1:0]);
            axis_nxt = 1'b1;
          end
          6'd1: begin
            qx_nxt = prod_r[SUM_W-1:0];
            op_nxt = OP_QR; axis_nxt = 1'b0;
          end
          6'd2: begin
            qy_nxt = prod_r[SUM_W-1:0];
            axis_nxt = 1'b1;
          end
          6'd3: qx_nxt = qx_r + SUM_W'(prod_r[63:DIV_SHIFT]);
          default: qy_nxt = qy_r + SUM_W'(prod_r[63:DIV_SHIFT]);
        endcase
      end
      S_END: begin
        dx_res_nxt = sat32(64'(pos_x_r) - 64'(ix));
        dy_res_nxt = sat32(64'(pos_y_r) - 64'(iy));
        slot_nxt = cnt_r[SLOT_W-1:0];
        rx_res_nxt = ix; ry_res_nxt = iy;
        cnt_nxt = cinc;
        if (cinc > CNT_W'(tlen_r)) begin
          cnt_nxt = '0; full_nxt = 1'b1;
          if (mode_r[1]) begin
            rx_res_nxt = start_x_r; ry_res_nxt = start_y_r;
          end
        end
        pos_x_nxt = rx_res_nxt; pos_y_nxt = ry_res_nxt;
      end
      S_EMIT: if (out_free) begin
        out_v_nxt = 1'b1;
        out_d_nxt = {7'd0, slot_r, dy_res_r, dx_res_r, ry_res_r, rx_res_r};
        out_u_nxt = {full_r, (rx_res_r < -lim) || (ry_res_r < -lim) ||
                             (rx_res_r > lim) || (ry_res_r > lim)};
      end
      default: out_v_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      pos_x_r <= '0; pos_y_r <= '0; start_x_r <= '0; start_y_r <= '0;
      cnt_r <= '0; full_r <= 1'b0;
      cx_abcd_r <= '0; cy_abcd_r <= '0;
      cx_efti_r <= 64'd17592186044416; cy_efti_r <= 64'd17592186044416;
      step_r <= 24'd167772; tlen_r <= 9'd500; mode_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      pos_x_r <= pos_x_nxt; pos_y_r <= pos_y_nxt;
      start_x_r <= start_x_nxt; start_y_r <= start_y_nxt;
      cnt_r <= cnt_nxt; full_r <= full_nxt;
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_X_ABCD:    cx_abcd_r <= cfg_wdata;
          CFG_X_EFTI:    cx_efti_r <= cfg_wdata;
          CFG_Y_ABCD:    cy_abcd_r <= cfg_wdata;
          CFG_Y_EFTI:    cy_efti_r <= cfg_wdata;
          CFG_STEP:      step_r <= cfg_wdata[23:0];
          CFG_TRAIL_LEN: tlen_r <= cfg_wdata[SLOT_W-1:0];
          CFG_RUN_MODE:  mode_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ex_r <= ex_nxt; ey_r <= ey_nxt;
    uu_r <= uu_nxt; vv_r <= vv_nxt; uv_r <= uv_nxt; d_r <= d_nxt;
    kx_r <= kx_nxt; ky_r <= ky_nxt; acc_r <= acc_nxt; prod_r <= prod_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; qx_r <= qx_nxt; qy_r <= qy_nxt;
    rx_r <= rx_nxt; ry_r <= ry_nxt; dcnt_r <= dcnt_nxt;
    op_r <= op_nxt; axis_r <= axis_nxt; stage_r <= stage_nxt;
    rx_res_r <= rx_res_nxt; ry_res_r <= ry_res_nxt;
    dx_res_r <= dx_res_nxt; dy_res_r <= dy_res_nxt; slot_r <= slot_nxt;
    out_d_r <= out_d_nxt; out_u_r <= out_u_nxt;
  end

endmodule

[rtl/rk4q_checker.sv]
module rk4q_checker
  import rk4q_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic [1:0]   out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[1] ##1 out_tvalid |-> out_tuser[1])
    else $error("trail wrap flag dropped");

endmodule

bind rk4_quadratic_field_particle_step rk4q_checker u_rk4q_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import rk4q_pkg::*;

  typedef struct {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] dx;
    logic [31:0] dy;
    logic        outside;
    logic [8:0]  slot;
    logic        wrapped;
  } step_result_t;

  class particle_scoreboard;
    logic [63:0] cx_abcd, cx_efti, cy_abcd, cy_efti;
    logic [23:0] dt;
    logic [8:0]  trail_len;
    logic [46:0] t_limit;
    logic [1:0]  mode;
    longint      px, py, sx, sy, clock_t;
    int          trail_n;
    bit          trail_full;
    step_result_t awaited[$];
    int          errors;
    int          n_adv, n_place, n_wraps;

    function new();
      cx_abcd = '0; cy_abcd = '0;
      cx_efti = 64'd17592186044416; cy_efti = 64'd17592186044416;
      dt = 24'd167772; trail_len = 9'd500; t_limit = 47'd167772160000; mode = '0;
      px = 0; py = 0; sx = 0; sy = 0; clock_t = 0; trail_n = 0; trail_full = 0;
      errors = 0; n_adv = 0; n_place = 0; n_wraps = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [63:0] val);
      case (idx)
        CFG_X_ABCD:     cx_abcd = val;
        CFG_X_EFTI:     cx_efti = val;
        CFG_Y_ABCD:     cy_abcd = val;
        CFG_Y_EFTI:     cy_efti = val;
        CFG_STEP:       dt = val[23:0];
        CFG_TRAIL_LEN:  trail_len = val[8:0];
        CFG_TIME_LIMIT: t_limit = val[46:0];
        CFG_RUN_MODE:   mode = val[1:0];
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint coef(logic [63:0] r, int i);
      return longint'($signed(r[16*i +: 16]));
    endfunction

    function longint axis_rate(logic [63:0] abcd, logic [63:0] efti, longint u, longint v);
      longint uu, vv, uv, acc, poly;
      uu = clamp32((u * u) >>> FRAC_BITS);
      vv = clamp32((v * v) >>> FRAC_BITS);
      uv = clamp32((u * v) >>> FRAC_BITS);
      acc = coef(abcd, 0) * (64'sd1 <<< FRAC_BITS) + coef(abcd, 1) * u + coef(abcd, 2) * v
          + coef(abcd, 3) * uu + coef(efti, 0) * vv + coef(efti, 1) * uv;
      poly = clamp32(acc >>> 12);
      return clamp32(((poly * coef(efti, 2)) >>> 12) + coef(efti, 3) * 4096);
    endfunction

    function void rk_stage(longint h, longint x, longint y, output longint kx, output longint ky);
      kx = (h * axis_rate(cx_abcd, cx_efti, x, y)) >>> 24;
      ky = (h * axis_rate(cy_abcd, cy_efti, y, x)) >>> 24;
    endfunction

    function void note_request(logic req, logic [31:0] in_x, logic [31:0] in_y);
      step_result_t r;
      longint h, k1x, k1y, k2x, k2y, k3x, k3y, k4x, k4y, ix, iy, nx, ny, lim;
      r.dx = '0; r.dy = '0; r.slot = '0;
      if (req == REQ_PLACE) begin
        n_place++;
        px = longint'($signed(in_x)); py = longint'($signed(in_y));
        sx = px; sy = py;
        nx = px; ny = py;
      end else begin
        n_adv++;
        h = mode[0] ? -longint'(dt) : longint'(dt);
        rk_stage(h, px, py, k1x, k1y);
        rk_stage(h, clamp32(px + (k1x >>> 1)), clamp32(py + (k1y >>> 1)), k2x, k2y);
        rk_stage(h, clamp32(px + (k2x >>> 1)), clamp32(py + (k2y >>> 1)), k3x, k3y);
        rk_stage(h, clamp32(px + k3x), clamp32(py + k3y), k4x, k4y);
        ix = clamp32(px + (k1x + 2 * k2x + 2 * k3x + k4x) / 6);
        iy = clamp32(py + (k1y + 2 * k2y + 2 * k3y + k4y) / 6);
        r.dx = 32'(clamp32(px - ix)); r.dy = 32'(clamp32(py - iy));
        nx = ix; ny = iy;
        r.slot = trail_n[8:0];
        trail_n++;
        if (trail_n > trail_len) begin
          n_wraps++;
          trail_full = 1;
          trail_n = 0;
          if (mode[1]) begin
            nx = sx; ny = sy;
          end
        end
        px = nx; py = ny;
        clock_t = clock_t + h;
        if ((clock_t < 0 ? -clock_t : clock_t) > longint'(t_limit)) clock_t = 0;
      end
      lim = 64'sd2 <<< FRAC_BITS;
      r.nx = 32'(nx); r.ny = 32'(ny);
      r.outside = (nx < -lim) || (ny < -lim) || (nx > lim) || (ny > lim);
      r.wrapped = trail_full;
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_result(logic [143:0] d, logic [1:0] u);
      step_result_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: %h %b", d, u);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (d[31:0] !== e.nx) begin
        $error("new_x expected %h got %h", e.nx, d[31:0]); errors++;
      end
      if (d[63:32] !== e.ny) begin
        $error("new_y expected %h got %h", e.ny, d[63:32]); errors++;
      end
      if (d[95:64] !== e.dx) begin
        $error("disp_x expected %h got %h", e.dx, d[95:64]); errors++;
      end
      if (d[127:96] !== e.dy) begin
        $error("disp_y expected %h got %h", e.dy, d[127:96]); errors++;
      end
      if (d[136:128] !== e.slot) begin
        $error("trail_slot expected %0d got %0d", e.slot, d[136:128]); errors++;
      end
      if (u[0] !== e.outside) begin
        $error("outside_box expected %b got %b", e.outside, u[0]); errors++;
      end
      if (u[1] !== e.wrapped) begin
        $error("trail_wrapped expected %b got %b", e.wrapped, u[1]); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;   // place_x, place_y
  logic [0:0]   in_tuser = '0;   // req_type
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [143:0] out_tdata;       // new_x, new_y, disp_x, disp_y, trail_slot, zero pad
  logic [1:0]   out_tuser;       // outside_box, trail_wrapped
  logic         cfg_wr_en = 0;
  logic [2:0]   cfg_addr = '0;
  logic [63:0]  cfg_wdata = '0;

  particle_scoreboard motion_sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  rk4_quadratic_field_particle_step i_dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom % 100) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      motion_sb.note_request(in_tuser[0], in_tdata[31:0], in_tdata[63:32]);
    if (rst_n && out_tvalid && out_tready)
      motion_sb.check_result(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(logic req, logic [31:0] x, logic [31:0] y);
    while (($urandom % 100) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= req;
    in_tdata <= {y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (motion_sb.awaited.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    cfg_wr_en <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    motion_sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom % 6)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  function automatic logic [63:0] pick_coef_word();
    return {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [31:0] pick_pos();
    if ($urandom % 5 == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000);
  endfunction

  initial begin
    logic [31:0] two;
    int p;
    two = 32'h02000000;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // boundary positions, then a few steps under reset settings
    send_request(REQ_PLACE, 32'h7fffffff, 32'h80000000);
    send_request(REQ_ADVANCE, '0, '0);
    send_request(REQ_PLACE, 32'h80000000, 32'h7fffffff);
    send_request(REQ_ADVANCE, '0, '0);
    send_request(REQ_PLACE, two, -two);
    send_request(REQ_PLACE, two + 1, -two - 1);
    send_request(REQ_PLACE, 32'hffffffff, 32'hffffffff);
    send_request(REQ_PLACE, 32'h00ff00ff, 32'hff00ff00);
    repeat (3) send_request(REQ_ADVANCE, 32'hffffffff, 32'hffffffff);
    drain();

    // short trail with restart, backward in time, saturating field
    write_reg(CFG_X_ABCD, 64'h7fff_7fff_7fff_7fff);
    write_reg(CFG_Y_ABCD, 64'h8000_8000_8000_8000);
    write_reg(CFG_TRAIL_LEN, 64'(9'd1));
    write_reg(CFG_RUN_MODE, 64'(2'd3));
    send_request(REQ_PLACE, 32'h00800000, 32'hff800000);
    repeat (5) send_request(REQ_ADVANCE, '0, '0);
    drain();

    for (p = 0; p < 8; p++) begin
      send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? (p % 4 == 1 ? 87 : 14) : 0;
      recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? (p % 4 == 2 ? 87 : 14) : 0;
      write_reg(CFG_X_ABCD, pick_coef_word());
      write_reg(CFG_X_EFTI, pick_coef_word());
      write_reg(CFG_Y_ABCD, pick_coef_word());
      write_reg(CFG_Y_EFTI, pick_coef_word());
      write_reg(CFG_STEP, 64'(p == 1 ? 24'd1 : p == 2 ? 24'hffffff
                              : 24'($urandom_range(1, 24'hffffff))));
      write_reg(CFG_TRAIL_LEN, 64'(p == 3 ? 9'd0 : p == 4 ? 9'd511 : p == 5 ? 9'd1
                                   : 9'($urandom_range(1, 40))));
      write_reg(CFG_TIME_LIMIT, 64'(p == 2 ? 47'd0 : p == 4 ? {47{1'b1}}
                                    : 47'({$urandom, $urandom})));
      write_reg(CFG_RUN_MODE, 64'(p % 4));
      repeat (235) begin
        if ($urandom % 100 < 15)
          send_request(REQ_PLACE, pick_pos(), pick_pos());
        else
          send_request(REQ_ADVANCE, $urandom, $urandom);
      end
      drain();
    end

    $display("Covered %0d advance and %0d place requests, %0d trail wraps, 8 settings.",
             motion_sb.n_adv, motion_sb.n_place, motion_sb.n_wraps);
    if (motion_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rk4q_pkg.sv
rtl/rk4_quadratic_field_particle_step.sv
rtl/rk4q_checker.sv
tb/sv/testbench.sv
